[rtl/gmps_pkg.sv]
// shared constants for the grid minimum path sum block
// field widths, register map and parameter defaults; no dependencies
package gmps_pkg;

  localparam int GMPS_MAX_COLS  = 1024;
  localparam int GMPS_SUM_WIDTH = 32;

  localparam int COST_W     = 16;
  localparam int OUT_W      = 32;
  localparam int COLS_REG_W = 11;
  localparam int ROWS_REG_W = 16;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    REG_GRID_COLS = 1'b0,
    REG_GRID_ROWS = 1'b1
  } reg_idx_e;

endpackage

[rtl/gmps_cell.sv]
// one stage of the row line buffer: holds one earlier path sum
// depends on gmps_pkg for default widths
module gmps_cell #(
  parameter int SUM_WIDTH = gmps_pkg::GMPS_SUM_WIDTH,
  parameter int CW        = 10,
  parameter int IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  logic [CW-1:0]        cols_last_i,
  input  logic [SUM_WIDTH-1:0] new_sum_i,
  input  logic [SUM_WIDTH-1:0] next_sum_i,
  output logic [SUM_WIDTH-1:0] sum_o
);
  import gmps_pkg::*;

  logic                 tail;
  logic [SUM_WIDTH-1:0] sum_q;

  // the cell at the last active column takes the fresh sum
  assign tail = (cols_last_i == CW'(IDX));

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sum_q <= tail ? new_sum_i : next_sum_i;
    end
  end

  assign sum_o = sum_q;

endmodule

[rtl/gmps_line.sv]
// row line buffer built as a chain of gmps_cell stages
// depends on gmps_pkg and gmps_cell
module gmps_line #(
  parameter int MAX_COLS  = gmps_pkg::GMPS_MAX_COLS,
  parameter int SUM_WIDTH = gmps_pkg::GMPS_SUM_WIDTH,
  parameter int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  logic [CW-1:0]        cols_last_i,
  input  logic [SUM_WIDTH-1:0] new_sum_i,
  output logic [SUM_WIDTH-1:0] up_sum_o
);
  import gmps_pkg::*;

  logic [SUM_WIDTH-1:0] tap [MAX_COLS+1];

  // nothing enters past the far end
  assign tap[MAX_COLS] = '0;

  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    gmps_cell #(
      .SUM_WIDTH(SUM_WIDTH),
      .CW       (CW),
      .IDX      (k)
    ) u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift_i),
      .cols_last_i(cols_last_i),
      .new_sum_i  (new_sum_i),
      .next_sum_i (tap[k+1]),
      .sum_o      (tap[k])
    );
  end

  // head of the chain holds the sum written one row of items ago
  assign up_sum_o = tap[0];

endmodule

[rtl/grid_min_path_sum.sv]
// grid_min_path_sum: least right/down path cost per cell of a raster cost grid
// results are registered in the output buffer; one item per cycle unless full,
// set by the single saturating add/min stage feeding a shifting line of cells
// a two-entry output buffer keeps input accepted while one result waits
// reset: grid 1x1, position at origin, output empty; line buffer not cleared
// depends on gmps_pkg and gmps_line
module grid_min_path_sum #(
  parameter int MAX_COLS  = gmps_pkg::GMPS_MAX_COLS,
  parameter int SUM_WIDTH = gmps_pkg::GMPS_SUM_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [gmps_pkg::COST_W-1:0]      cell_cost_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [gmps_pkg::OUT_W-1:0]       path_sum_o,
  output logic                             last_cell_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gmps_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [gmps_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [gmps_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import gmps_pkg::*;

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic                  cfg_wr;
  reg_idx_e              cfg_idx;
  logic [COLS_REG_W-1:0] grid_cols_q;
  logic [ROWS_REG_W-1:0] grid_rows_q;
  logic [CW-1:0]         cols_last_q, cols_last_d;   // effective columns - 1
  logic [ROWS_REG_W-1:0] rows_last_q, rows_last_d;   // effective rows - 1
  logic [COLS_REG_W-1:0] wr_cols;
  logic [ROWS_REG_W-1:0] wr_rows;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign wr_cols = pwdata[COLS_REG_W-1:0];
  assign wr_rows = pwdata[ROWS_REG_W-1:0];

  always_comb begin
    unique case (cfg_idx)
      REG_GRID_COLS: prdata = APB_DATA_W'(grid_cols_q);
      REG_GRID_ROWS: prdata = APB_DATA_W'(grid_rows_q);
      default:       prdata = '0;
    endcase
  end

  // zero columns act as one, too many columns clamp to the line length
  always_comb begin
    if (wr_cols == '0) begin
      cols_last_d = '0;
    end else if (32'(wr_cols) > 32'(MAX_COLS)) begin
      cols_last_d = CW'(MAX_COLS - 1);
    end else begin
      cols_last_d = CW'(wr_cols - 1'b1);
    end
    rows_last_d = (wr_rows == '0) ? '0 : wr_rows - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= COLS_REG_W'(1);
      grid_rows_q <= ROWS_REG_W'(1);
      cols_last_q <= '0;
      rows_last_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GRID_COLS: begin
          grid_cols_q <= wr_cols;
          cols_last_q <= cols_last_d;
        end
        REG_GRID_ROWS: begin
          grid_rows_q <= wr_rows;
          rows_last_q <= rows_last_d;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // grid position and the cell update
  // ---------------------------------------------------------------
  logic                  in_acc;
  logic [CW-1:0]         col_q;
  logic [ROWS_REG_W-1:0] row_q;
  logic [SUM_WIDTH-1:0]  left_q;
  logic [SUM_WIDTH-1:0]  up_sum;
  logic [SUM_WIDTH-1:0]  best;
  logic [SUM_WIDTH:0]    raw_sum;
  logic [SUM_WIDTH-1:0]  new_sum;
  logic                  first_row, first_col, col_end, row_end, is_last;

  assign in_acc    = in_valid_i && in_ready_o;
  assign first_row = (row_q == '0);
  assign first_col = (col_q == '0);
  assign col_end   = (col_q == cols_last_q);
  assign row_end   = (row_q == rows_last_q);
  assign is_last   = col_end && row_end;

  // pick the cheaper neighbor; the origin starts from zero
  always_comb begin
    priority if (first_row && first_col) begin
      best = '0;
    end else if (first_row) begin
      best = left_q;
    end else if (first_col) begin
      best = up_sum;
    end else begin
      best = (up_sum < left_q) ? up_sum : left_q;
    end
  end

  // saturating add at the top of the sum range
  assign raw_sum = {1'b0, best} + (SUM_WIDTH+1)'(cell_cost_i);
  assign new_sum = raw_sum[SUM_WIDTH] ? '1 : raw_sum[SUM_WIDTH-1:0];

  // a register write restarts the grid at the origin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (cfg_wr) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (in_acc) begin
      left_q <= new_sum;
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // line of cells carrying the previous row's sums
  gmps_line #(
    .MAX_COLS (MAX_COLS),
    .SUM_WIDTH(SUM_WIDTH),
    .CW       (CW)
  ) u_line (
    .clk_i      (clk_i),
    .shift_i    (in_acc),
    .cols_last_i(cols_last_q),
    .new_sum_i  (new_sum),
    .up_sum_o   (up_sum)
  );

  // clamp or widen the sum to the result field
  logic [OUT_W-1:0] out_sum;

  if (SUM_WIDTH > OUT_W) begin : g_clamp
    assign out_sum = (|new_sum[SUM_WIDTH-1:OUT_W]) ? '1 : new_sum[OUT_W-1:0];
  end else begin : g_widen
    assign out_sum = OUT_W'(new_sum);
  end

  // ---------------------------------------------------------------
  // two-entry output buffer: head register plus skid register
  // ---------------------------------------------------------------
  logic [1:0]       cnt_q;
  logic [OUT_W-1:0] head_sum_q, skid_sum_q;
  logic             head_last_q, skid_last_q;
  logic             out_acc;

  assign out_acc     = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign in_ready_o  = (cnt_q != 2'd2);
  assign path_sum_o  = head_sum_q;
  assign last_cell_o = head_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    // head register
    if (out_acc && (cnt_q == 2'd2)) begin
      head_sum_q  <= skid_sum_q;
      head_last_q <= skid_last_q;
    end else if (in_acc && ((cnt_q == 2'd0) || out_acc)) begin
      head_sum_q  <= out_sum;
      head_last_q <= is_last;
    end
    // skid register fills only when the head is held
    if (in_acc && (cnt_q == 2'd1) && !out_acc) begin
      skid_sum_q  <= out_sum;
      skid_last_q <= is_last;
    end
  end

endmodule

[dv/gmps_path_checker.sv]
// result checker for grid_min_path_sum: watches both item channels and the config port
// keeps its own copy of the grid state and line buffer; depends on gmps_pkg
module gmps_path_checker
  import gmps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [COST_W-1:0]     cell_cost_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_W-1:0]      path_sum_i,
  input  logic                  last_cell_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  input  logic [APB_DATA_W-1:0] prdata_i,
  input  logic                  pready_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o
);

  localparam int SUM_W        = GMPS_SUM_WIDTH;
  localparam int REPORT_LIMIT = 20;
  localparam logic [APB_ADDR_W-1:0] COLS_ADDR = APB_ADDR_W'(4 * int'(REG_GRID_COLS));
  localparam logic [APB_ADDR_W-1:0] ROWS_ADDR = APB_ADDR_W'(4 * int'(REG_GRID_ROWS));
  localparam logic [SUM_W:0]        SUM_TOP   = {1'b0, {SUM_W{1'b1}}};

  typedef struct packed {
    logic [OUT_W-1:0] path_sum;
    logic             last_cell;
  } cell_result_t;

  cell_result_t          awaited_q[$];
  logic [COLS_REG_W-1:0] cols_reg;
  logic [ROWS_REG_W-1:0] rows_reg;
  logic [SUM_W-1:0]      line_sums [GMPS_MAX_COLS];
  logic [SUM_W-1:0]      left_sum;
  int unsigned           col_pos;
  int unsigned           row_pos;
  int unsigned           fails   = 0;
  int unsigned           checked = 0;

  task automatic report(input string msg);
    fails++;
    if (fails <= REPORT_LIMIT) begin
      $error("%s", msg);
    end
  endtask

  task automatic restart_grid();
    left_sum = '0;
    col_pos  = 0;
    row_pos  = 0;
  endtask

  // one raster step: min of left/up plus own cost, saturating, then advance position
  function automatic cell_result_t predict_cell(input logic [COST_W-1:0] cost);
    int unsigned      cols;
    int unsigned      rows;
    int unsigned      c;
    int unsigned      r;
    logic [SUM_W-1:0] base;
    logic [SUM_W:0]   total;
    cell_result_t     res;
    cols = (cols_reg == 0) ? 1 : ((cols_reg > GMPS_MAX_COLS) ? GMPS_MAX_COLS : cols_reg);
    rows = (rows_reg == 0) ? 1 : rows_reg;
    c = (col_pos >= cols) ? cols - 1 : col_pos;
    r = (row_pos >= rows) ? rows - 1 : row_pos;
    if (r == 0 && c == 0) begin
      base = '0;
    end else if (r == 0) begin
      base = left_sum;
    end else if (c == 0) begin
      base = line_sums[0];
    end else begin
      base = (line_sums[c] < left_sum) ? line_sums[c] : left_sum;
    end
    total = {1'b0, base} + cost;
    if (total > SUM_TOP) begin
      total = SUM_TOP;
    end
    line_sums[c] = total[SUM_W-1:0];
    left_sum     = total[SUM_W-1:0];
    res.last_cell = (r == rows - 1) && (c == cols - 1);
    if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    res.path_sum = (65'(total) > 65'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(total);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t want;
    if (!rst_ni) begin
      cols_reg = 1;
      rows_reg = 1;
      restart_grid();
      awaited_q.delete();
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i == COLS_ADDR) begin
            cols_reg = pwdata_i[COLS_REG_W-1:0];
            restart_grid();
          end else if (paddr_i == ROWS_ADDR) begin
            rows_reg = pwdata_i[ROWS_REG_W-1:0];
            restart_grid();
          end
        end else if (paddr_i == COLS_ADDR && prdata_i !== APB_DATA_W'(cols_reg)) begin
          report($sformatf("prdata grid_cols: expected %0d, got %0d", cols_reg, prdata_i));
        end else if (paddr_i == ROWS_ADDR && prdata_i !== APB_DATA_W'(rows_reg)) begin
          report($sformatf("prdata grid_rows: expected %0d, got %0d", rows_reg, prdata_i));
        end
      end
      // push before pop so a same-edge result still finds its prediction
      if (in_valid_i && in_ready_i) begin
        awaited_q.push_back(predict_cell(cell_cost_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          report($sformatf("result item with nothing awaited: path_sum %0d last_cell %0d",
                           path_sum_i, last_cell_i));
        end else begin
          want = awaited_q.pop_front();
          if (path_sum_i !== want.path_sum) begin
            report($sformatf("path_sum: expected %0d, got %0d", want.path_sum, path_sum_i));
          end
          if (last_cell_i !== want.last_cell) begin
            report($sformatf("last_cell: expected %0d, got %0d", want.last_cell, last_cell_i));
          end
          checked++;
        end
      end
    end
    pending_o    <= awaited_q.size();
    fail_count_o <= fails;
    checked_o    <= checked;
  end

endmodule

[dv/grid_min_path_sum_test.sv]
// testbench top for grid_min_path_sum: drives cost items, the result sink and the config port
// depends on gmps_pkg, grid_min_path_sum and gmps_path_checker
module grid_min_path_sum_test;
  import gmps_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1350;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [COST_W-1:0]     cell_cost_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [OUT_W-1:0]      path_sum_o;
  logic                  last_cell_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned fail_count;
  int unsigned cells_pending;
  int unsigned results_checked;

  // stimulus bookkeeping
  logic [COST_W-1:0] cost_plan[$];     // costs queued for the next run of items
  int unsigned       items_sent      = 0;
  int unsigned       configs_written = 0;
  int unsigned       hold_requests   = 0;  // bumped to ask the sink for one long hold-off
  bit                sink_steady     = 1'b0;

  grid_min_path_sum u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cell_cost_i (cell_cost_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .path_sum_o  (path_sum_o),
    .last_cell_o (last_cell_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  gmps_path_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .cell_cost_i  (cell_cost_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .path_sum_i   (path_sum_o),
    .last_cell_i  (last_cell_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (cells_pending),
    .checked_o    (results_checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // gap lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // cost mix: full-range noise, small values so left/up ties and flips happen,
  // near-max values to push sums high, and plain zero
  function automatic logic [COST_W-1:0] pick_cost();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return COST_W'($urandom());
    if (roll < 75) return COST_W'($urandom_range(0, 15));
    if (roll < 90) return {COST_W{1'b1}} - COST_W'($urandom_range(0, 3));
    return '0;
  endfunction

  // send every queued cost; valid stays up between items unless a gap is taken
  task automatic run_plan(input bit steady);
    int unsigned gap;
    while (cost_plan.size() != 0) begin
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      cell_cost_i <= cost_plan.pop_front();
      do @(posedge clk_i); while (!in_ready_o);
      items_sent++;
    end
    in_valid_i <= 1'b0;
  endtask

  // wait until every predicted result has been taken, then let the pipe settle
  task automatic drain();
    do @(posedge clk_i); while (cells_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // setup cycle, access cycle, done when pready is seen high in the access phase
  task automatic apb_access(input reg_idx_e idx, input bit wr, input logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'(4 * int'(idx));
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // idle the block, then write and read back both registers; each write restarts the grid
  // bits above the register width carry noise that the block must drop
  task automatic configure(input int unsigned cols, input int unsigned rows);
    logic [APB_DATA_W-1:0] word;
    drain();
    word = $urandom();
    word[COLS_REG_W-1:0] = COLS_REG_W'(cols);
    apb_access(REG_GRID_COLS, 1'b1, word);
    apb_access(REG_GRID_COLS, 1'b0, '0);
    word = $urandom();
    word[ROWS_REG_W-1:0] = ROWS_REG_W'(rows);
    apb_access(REG_GRID_ROWS, 1'b1, word);
    apb_access(REG_GRID_ROWS, 1'b0, '0);
    configs_written++;
  endtask

  // result sink: random stalls, steady stretches, and on request one long hold-off
  // counted here so the sender keeps pushing into a full block
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holds_done;
    stall_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!sink_steady) stall_left = pick_gap();
      end
    end
  end

  // hard stop if anything hangs
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results still awaited", cycle_count, cells_pending);
    $display("grid_min_path_sum_test: errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned cols;
    int unsigned rows;
    int unsigned cells;
    int unsigned n;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // after reset the grid is 1x1, so each item is a whole grid on its own
    cost_plan = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001};
    run_plan(1'b0);

    // zero columns and zero rows both behave as one
    configure(0, 0);
    cost_plan = '{16'h8000, 16'h7FFF};
    run_plan(1'b1);

    // 3x2 grid where the bottom row takes the upper path once and the left path once,
    // then two cells into the next grid before a register write restarts it
    configure(3, 2);
    cost_plan = '{16'd5, 16'd1, 16'd9, 16'd2, 16'd7, 16'd0, 16'hFFFF, 16'd3};
    run_plan(1'b0);

    // column count above the line buffer size clamps to the buffer size
    configure(2047, 1);
    repeat (GMPS_MAX_COLS + 6) cost_plan.push_back(pick_cost());
    run_plan(1'b0);

    // back-pressure: sink holds off for a long stretch while items keep coming
    configure(5, 4);
    hold_requests++;
    repeat (40) cost_plan.push_back(pick_cost());
    run_plan(1'b1);

    // random shapes, mostly small, with partial grids cut short by the next write
    while (items_sent < ITEM_TARGET) begin
      cols = ($urandom_range(0, 9) == 0) ? 0 :
             (($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
      rows = ($urandom_range(0, 9) == 0) ? 0 :
             (($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6));
      configure(cols, rows);
      cells = ((cols == 0) ? 1 : cols) * ((rows == 0) ? 1 : rows);
      n = cells * $urandom_range(1, 2) + $urandom_range(0, cells - 1);
      if (n > 240) n = 240;
      if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;
      repeat (n) cost_plan.push_back(pick_cost());
      sink_steady = ($urandom_range(0, 4) == 0);
      run_plan($urandom_range(0, 4) == 0);
    end

    drain();
    $display("covered %0d cost items over %0d grid settings, %0d results compared",
             items_sent, configs_written, results_checked);
    $display("shapes from 1x1 to 40x20, column clamp, zero sizes, restarts and a long stall");
    if (fail_count == 0) begin
      $display("grid_min_path_sum_test: clean");
    end else begin
      $display("grid_min_path_sum_test: errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/gmps_pkg.sv
rtl/gmps_cell.sv
rtl/gmps_line.sv
rtl/grid_min_path_sum.sv
dv/gmps_path_checker.sv
dv/grid_min_path_sum_test.sv
